// ----- hdl/gcsm_pkg.sv -----
// Shared types, constants and helpers for the grid cell set merger.
package gcsm_pkg;

	localparam int MAX_SIDE   = 16;
	localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
	localparam int IDX_W      = $clog2(CELL_COUNT);
	localparam int LABEL_W    = IDX_W;
	localparam int COORD_W    = $clog2(MAX_SIDE);
	localparam int SPAN_W     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 4 * COORD_W;
	localparam int OUT_DATA_W = 8;

	localparam logic [SPAN_W-1:0]    SPAN_RESET      = SPAN_W'(10);
	localparam logic [SPAN_W-1:0]    SPAN_MAX        = SPAN_W'(MAX_SIDE);
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(1);
	localparam logic                 OP_CLEAR        = 1'b0;
	localparam logic                 OP_EDGE         = 1'b1;
	localparam logic [IDX_W-1:0]     WALK_LAST       = IDX_W'(CELL_COUNT - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ_A,
		ST_READ_B,
		ST_CHECK,
		ST_WALK,
		ST_FINISH
	} gcsm_state_t;

	typedef struct packed {
		logic load;
		logic clear_sets;
		logic read_a;
		logic read_b;
		logic check;
		logic walk;
		logic emit;
	} gcsm_cmd_t;

	typedef struct packed {
		logic op_edge;
		logic out_of_grid;
		logic labels_differ;
		logic walk_last;
		logic out_free;
	} gcsm_sts_t;

	// grid register values above the store size clamp to the store size
	function automatic logic [SPAN_W-1:0] span_in_use(input logic [SPAN_W-1:0] reg_val);
		return (reg_val > SPAN_MAX) ? SPAN_MAX : reg_val;
	endfunction

endpackage

// ----- hdl/grid_cell_set_merger_core.sv -----
// Top level of the grid cell set merger: union-find by relabelling for maze building.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser[0] op; s_tdata first_x, first_y, second_x, second_y
//  m_      | out | m_tvalid/m_tready  | m_tdata joined, out_of_grid, zero fill
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// Clear and out-of-grid items pass through the decode and finish states; the result is valid
// in the same cycle in which the next beat can be taken.
// Edge in one set: read A, read B and check, then finish. A merging edge adds a walk over all
// 256 label entries through the single read port of the label RAM, one entry a cycle.
// Reset needs no clearing pass: per-cell valid bits make unwritten cells read as their index.
// A stalled result beat sits in the output register; the input side is not blocked by it
// until the next result is ready.
module grid_cell_set_merger_core
	import gcsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // first_x, first_y, second_x, second_y
	input  logic [0:0]            s_tuser,   // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // joined, out_of_grid, zero fill
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [SPAN_W-1:0]     cfg_data
);

	gcsm_cmd_t cmd;
	gcsm_sts_t sts;

	assign cfg_ready = 1'b1;

	gcsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gcsm_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- hdl/gcsm_ram.sv -----
// Generic simple dual-port RAM with registered read.
module gcsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/gcsm_ctrl.sv -----
// Controller state machine: sequences decode, label reads, compare and relabel walk.
module gcsm_ctrl
	import gcsm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  gcsm_sts_t sts,
	output gcsm_cmd_t cmd
);

	gcsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!sts.op_edge) begin
					cmd.clear_sets = 1'b1;
					state_d        = ST_FINISH;
				end else if (sts.out_of_grid) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_READ_A;
				end
			end
			ST_READ_A: begin
				cmd.read_a = 1'b1;
				state_d    = ST_READ_B;
			end
			ST_READ_B: begin
				cmd.read_b = 1'b1;
				state_d    = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = sts.labels_differ ? ST_WALK : ST_FINISH;
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/gcsm_dpath.sv -----
// Datapath: grid registers, item latch, label store with valid bits, walk and result register.
module gcsm_dpath
	import gcsm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [0:0]             s_tuser,
	input  logic [IN_DATA_W-1:0]   s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,
	input  logic                   cfg_valid,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [SPAN_W-1:0]      cfg_data,
	input  gcsm_cmd_t              cmd,
	output gcsm_sts_t              sts
);

	logic [SPAN_W-1:0]   grid_width_q, grid_height_q;
	logic [SPAN_W-1:0]   span_w, span_h;
	logic                op_q;
	logic [COORD_W-1:0]  ax_q, ay_q, bx_q, by_q;
	logic                outside;
	logic [IDX_W-1:0]    walk_cnt_q;
	logic [IDX_W-1:0]    raddr;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic                rd_walk_s1;
	logic [LABEL_W-1:0]  rdata;
	logic [LABEL_W-1:0]  eff_label;
	logic [LABEL_W-1:0]  la_q, lb_q;
	logic [CELL_COUNT-1:0] valid_q;
	logic                join_q;
	logic                we;
	logic                m_tvalid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// config channel; writes are expected only while no item is in work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= SPAN_RESET;
			grid_height_q <= SPAN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign span_w = span_in_use(grid_width_q);
	assign span_h = span_in_use(grid_height_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= s_tuser[0];
			ax_q <= s_tdata[COORD_W-1:0];
			ay_q <= s_tdata[2*COORD_W-1:COORD_W];
			bx_q <= s_tdata[3*COORD_W-1:2*COORD_W];
			by_q <= s_tdata[4*COORD_W-1:3*COORD_W];
		end
	end

	assign outside = ({1'b0, ax_q} >= span_w) || ({1'b0, bx_q} >= span_w) ||
		({1'b0, ay_q} >= span_h) || ({1'b0, by_q} >= span_h);

	always_comb begin
		raddr = walk_cnt_q;
		if (cmd.read_a) begin
			raddr = {ay_q, ax_q};
		end else if (cmd.read_b) begin
			raddr = {by_q, bx_q};
		end
	end

	gcsm_ram #(
		.WIDTH(LABEL_W),
		.DEPTH(CELL_COUNT)
	) u_label_ram (
		.clk   (clk),
		.we    (we),
		.waddr (rd_idx_s1),
		.wdata (la_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// a cell never written since the last clear or reset reads as its own index
	assign eff_label = valid_q[rd_idx_s1] ? rdata : rd_idx_s1;
	assign we        = rd_walk_s1 && (eff_label == lb_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_walk_s1 <= 1'b0;
			walk_cnt_q <= '0;
		end else begin
			rd_walk_s1 <= cmd.walk;
			if (cmd.clear_sets) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[rd_idx_s1] <= 1'b1;
			end
			if (cmd.check) begin
				walk_cnt_q <= '0;
			end else if (cmd.walk) begin
				walk_cnt_q <= walk_cnt_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= raddr;
		if (cmd.read_b) begin
			la_q <= eff_label;
		end
		if (cmd.check) begin
			lb_q <= eff_label;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			join_q <= 1'b0;
		end else if (cmd.load) begin
			join_q <= 1'b0;
		end else if (cmd.check) begin
			join_q <= (la_q != eff_label);
		end
	end

	// result register: frees the input side while a beat waits downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {{(OUT_DATA_W-2){1'b0}}, (op_q == OP_EDGE) && outside, join_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;

	assign sts.op_edge       = (op_q == OP_EDGE);
	assign sts.out_of_grid   = outside;
	assign sts.labels_differ = (la_q != eff_label);
	assign sts.walk_last     = (walk_cnt_q == WALK_LAST);
	assign sts.out_free      = !m_tvalid_q || m_tready;

endmodule

// ----- hdl/gcsm_checker.sv -----
// Port-level checks for the grid cell set merger, bound to the top level.
module gcsm_checker
	import gcsm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one item in flight: input closes right after a beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// an out-of-grid edge never merges
	a_oog_no_join: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("result flags both join and out of grid");

	// with no beat pending at acceptance, no result beat shows before the item has left decode and finish
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid ##1 !m_tvalid)
		else $error("result appeared too early");

endmodule

bind grid_cell_set_merger_core gcsm_checker u_gcsm_checker (.*);
